@@ rtl/core/rtlt_pkg.sv @@
// shared types and constants for the row timestamp lock table
// no dependencies; used by rtlt_update and row_timestamp_lock_table
package rtlt_pkg;

  // field widths fixed by the request format
  localparam int unsigned STAMP_W   = 64;
  localparam int unsigned ROW_W     = 10;
  localparam int unsigned ACTION_W  = 4;
  // wide enough to hold any row count up to 65536
  localparam int unsigned ROW_EXT_W = 17;
  localparam int unsigned ROWS_DEF  = 1024;

  typedef logic [STAMP_W-1:0] stamp_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_READ    = 4'd0,
    ACT_LOCK    = 4'd1,
    ACT_UPDATE  = 4'd2,
    ACT_RAISE   = 4'd3,
    ACT_INSTALL = 4'd4,
    ACT_RENEW   = 4'd5,
    ACT_RELEASE = 4'd6,
    ACT_DELETE  = 4'd7,
    ACT_SET     = 4'd8
  } action_t;

  // one row of metadata as held in the table memory
  typedef struct packed {
    stamp_t wts;
    stamp_t rts;
    logic   locked;
    logic   deleted;
    stamp_t dts;
  } row_entry_t;

  // result of one request
  typedef struct packed {
    logic   ok;
    stamp_t wts;
    stamp_t rts;
  } result_t;

endpackage

@@ rtl/core/rtlt_update.sv @@
// modify step of the read-modify-write: new row contents and the result
// depends on rtlt_pkg
module rtlt_update (
  input  logic [rtlt_pkg::ACTION_W-1:0] action,
  input  logic                          row_ok,
  input  rtlt_pkg::stamp_t              wts_in,
  input  rtlt_pkg::stamp_t              rts_in,
  input  rtlt_pkg::row_entry_t          cur,
  output rtlt_pkg::row_entry_t          nxt,
  output logic                          wr_en,
  output rtlt_pkg::result_t             res
);

  rtlt_pkg::stamp_t raised_rts;

  // read stamp raised to the request stamp
  assign raised_rts = (rts_in > cur.rts) ? rts_in : cur.rts;

  // per action update and result
  always_comb begin
    nxt   = cur;
    wr_en = 1'b0;
    res   = '0;
    if (row_ok) begin
      unique case (rtlt_pkg::action_t'(action))
        rtlt_pkg::ACT_READ: begin
          res = '{ok: 1'b1, wts: cur.wts, rts: cur.rts};
        end
        rtlt_pkg::ACT_LOCK: begin
          if (!cur.locked) begin
            nxt.locked = 1'b1;
            wr_en      = 1'b1;
            res        = '{ok: 1'b1, wts: cur.wts, rts: cur.rts};
          end
        end
        rtlt_pkg::ACT_UPDATE: begin
          if (wts_in > cur.wts) begin
            nxt.wts = wts_in;
            nxt.rts = rts_in;
            wr_en   = 1'b1;
          end
          res.ok = 1'b1;
        end
        rtlt_pkg::ACT_RAISE: begin
          nxt.rts = raised_rts;
          wr_en   = 1'b1;
          res.ok  = 1'b1;
        end
        rtlt_pkg::ACT_INSTALL: begin
          nxt.wts = wts_in;
          nxt.rts = wts_in;
          wr_en   = 1'b1;
          res.ok  = 1'b1;
        end
        rtlt_pkg::ACT_RENEW: begin
          // version must match; deleted rows check the deletion stamp only
          if (wts_in == cur.wts) begin
            if (cur.deleted) begin
              if (rts_in < cur.dts) begin
                res.ok  = 1'b1;
                res.rts = cur.rts;
              end
            end else if (!cur.locked) begin
              nxt.rts = raised_rts;
              wr_en   = 1'b1;
              res.ok  = 1'b1;
              res.rts = raised_rts;
            end
          end
        end
        rtlt_pkg::ACT_RELEASE: begin
          nxt.locked = 1'b0;
          wr_en      = 1'b1;
          res.ok     = 1'b1;
        end
        rtlt_pkg::ACT_DELETE: begin
          nxt.deleted = 1'b1;
          nxt.dts     = wts_in;
          wr_en       = 1'b1;
          res.ok      = 1'b1;
        end
        rtlt_pkg::ACT_SET: begin
          nxt.wts = wts_in;
          nxt.rts = rts_in;
          wr_en   = 1'b1;
          res.ok  = 1'b1;
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/row_timestamp_lock_table.sv @@
// Row timestamp lock table: per-row write stamp, read stamp, lock bit,
// deleted flag and deletion stamp, held in one single-port-write memory of
// ROWS entries. The memory is read at the input transfer into a read register
// while the request is held pending; once the result register is free or
// draining, the entry is updated, written back and the result registered,
// which raises out_valid. A new request can be taken every cycle while the
// result register drains; back-to-back requests to the same row
// are served by forwarding the written entry. After reset a clearing pass
// zeroes the memory one entry per cycle, with in_stall held high. A row
// index at or beyond ROWS or an unknown action returns ok low with zero
// stamps and changes nothing.
// depends on rtlt_pkg and rtlt_update
module row_timestamp_lock_table #(
  parameter int unsigned ROWS = rtlt_pkg::ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rtlt_pkg::ACTION_W-1:0] in_action,
  input  logic [rtlt_pkg::ROW_W-1:0]    in_row_index,
  input  logic [rtlt_pkg::STAMP_W-1:0]  in_wts_in,
  input  logic [rtlt_pkg::STAMP_W-1:0]  in_rts_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_ok,
  output logic [rtlt_pkg::STAMP_W-1:0]  out_wts_out,
  output logic [rtlt_pkg::STAMP_W-1:0]  out_rts_out
);

  localparam int unsigned AW = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic                              in_xfer;
  logic                              fire;
  logic [rtlt_pkg::ROW_EXT_W-1:0]    row_ext;
  logic [AW-1:0]                     acc_idx;
  logic                              acc_row_ok;

  // table memory
  rtlt_pkg::row_entry_t              mem [ROWS];
  rtlt_pkg::row_entry_t              rd_data_r;
  logic                              mem_we;
  logic [AW-1:0]                     mem_waddr;
  rtlt_pkg::row_entry_t              mem_wdata;

  // clearing pass
  logic                              clr_r;
  logic [AW-1:0]                     clr_cnt_r;

  // request waiting for its read data
  logic                              pend_r;
  logic [rtlt_pkg::ACTION_W-1:0]     pend_act_r;
  logic [AW-1:0]                     pend_row_r;
  logic                              pend_rowok_r;
  rtlt_pkg::stamp_t                  pend_wts_r;
  rtlt_pkg::stamp_t                  pend_rts_r;

  // forwarding of a write to the row just read
  logic                              fwd_hit_r;
  rtlt_pkg::row_entry_t              fwd_data_r;
  rtlt_pkg::row_entry_t              cur_entry;

  // update results
  rtlt_pkg::row_entry_t              upd_entry;
  logic                              upd_we;
  rtlt_pkg::result_t                 upd_res;

  // result register
  logic                              out_valid_r;
  rtlt_pkg::result_t                 out_res_r;

  // handshake
  assign fire     = pend_r & (~out_valid_r | ~out_stall);
  assign in_stall = clr_r | (pend_r & ~fire);
  assign in_xfer  = in_valid & ~in_stall;

  // row index range check and memory address
  assign row_ext    = {{(rtlt_pkg::ROW_EXT_W - rtlt_pkg::ROW_W){1'b0}}, in_row_index};
  assign acc_idx    = row_ext[AW-1:0];
  assign acc_row_ok = row_ext < rtlt_pkg::ROW_EXT_W'(ROWS);

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      if (clr_cnt_r == AW'(ROWS - 1)) begin
        clr_r <= 1'b0;
      end else begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  // write port select
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pend_row_r;
    mem_wdata = upd_entry;
    if (clr_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (fire && upd_we) begin
      mem_we = 1'b1;
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_xfer) begin
      rd_data_r <= mem[acc_idx];
    end
  end

  // pending request control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      pend_r <= in_xfer | (pend_r & ~fire);
      if (in_xfer) begin
        fwd_hit_r <= fire & mem_we & (pend_row_r == acc_idx);
      end
    end
  end

  // pending request payload and forwarded entry
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pend_act_r   <= in_action;
      pend_row_r   <= acc_idx;
      pend_rowok_r <= acc_row_ok;
      pend_wts_r   <= in_wts_in;
      pend_rts_r   <= in_rts_in;
      fwd_data_r   <= upd_entry;
    end
  end

  assign cur_entry = fwd_hit_r ? fwd_data_r : rd_data_r;

  // modify step
  rtlt_update u_update (
    .action (pend_act_r),
    .row_ok (pend_rowok_r),
    .wts_in (pend_wts_r),
    .rts_in (pend_rts_r),
    .cur    (cur_entry),
    .nxt    (upd_entry),
    .wr_en  (upd_we),
    .res    (upd_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fire | (out_valid_r & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= upd_res;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_ok      = out_res_r.ok;
  assign out_wts_out = out_res_r.wts;
  assign out_rts_out = out_res_r.rts;

`ifndef SYNTHESIS
  // a new result only comes from a request that was waiting
  a_result_from_pend: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pend_r))
    else $error("result without a pending request");

  // no request in flight while the memory is being cleared
  a_no_pend_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !pend_r && !out_valid_r)
    else $error("request in flight during clearing pass");

  // a failed request returns zero stamps
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ok |-> out_wts_out == '0 && out_rts_out == '0)
    else $error("failed request with nonzero stamps");

  // a write to the same row at the input transfer is always forwarded to the new request
  a_fwd_row: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && fire && mem_we && pend_row_r == acc_idx |=> fwd_hit_r && pend_r)
    else $error("missed forwarding on same-row request");
`endif

endmodule

@@ tb/row_timestamp_lock_table_tb.sv @@
// testbench for row_timestamp_lock_table: directed and random requests with
// random idling on both channels, checked against an in-bench row table model
// depends on rtlt_pkg and row_timestamp_lock_table
`timescale 1ns / 100ps

module row_timestamp_lock_table_tb;
  import rtlt_pkg::*;

  localparam int unsigned TB_ROWS = ROWS_DEF;
  // action codes the block does not define
  localparam logic [ACTION_W-1:0] ACT_UNDEF_LO = 4'd9;
  localparam logic [ACTION_W-1:0] ACT_UNDEF_HI = 4'd15;
  localparam int unsigned RANDOM_ITEMS = 450;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ROW_W-1:0]    row;
    stamp_t              wts;
    stamp_t              rts;
  } row_request_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [ACTION_W-1:0] in_action = '0;
  logic [ROW_W-1:0]    in_row_index = '0;
  stamp_t              in_wts_in = '0;
  stamp_t              in_rts_in = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_ok;
  stamp_t              out_wts_out;
  stamp_t              out_rts_out;

  // model of the row table, all zero after reset
  bit [STAMP_W-1:0] tbl_wts [TB_ROWS];
  bit [STAMP_W-1:0] tbl_rts [TB_ROWS];
  bit               tbl_locked [TB_ROWS];
  bit               tbl_deleted [TB_ROWS];
  bit [STAMP_W-1:0] tbl_dts [TB_ROWS];

  row_request_t pending_reqs[$];
  result_t      expected_results[$];
  row_request_t offered_req;
  int           tx_gap = 0;
  int           rx_stall_left = 0;
  int           accepted_count = 0;
  int           mismatch_count = 0;
  int           random_count = 0;
  bit           pause_tx = 1'b0;
  bit           no_idle = 1'b0;
  bit           rx_hold = 1'b0;

  row_timestamp_lock_table #(
    .ROWS(TB_ROWS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_row_index(in_row_index),
    .in_wts_in(in_wts_in),
    .in_rts_in(in_rts_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_ok(out_ok),
    .out_wts_out(out_wts_out),
    .out_rts_out(out_rts_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // applies one request to the row table and returns its result
  function automatic result_t apply_row_request(input row_request_t rq);
    result_t res;
    int unsigned i;
    res = '0;
    i = 32'(rq.row);
    if (i < TB_ROWS) begin
      case (rq.action)
        ACT_READ: begin
          res.ok = 1'b1;
          res.wts = tbl_wts[i];
          res.rts = tbl_rts[i];
        end
        ACT_LOCK: begin
          if (!tbl_locked[i]) begin
            tbl_locked[i] = 1'b1;
            res.ok = 1'b1;
            res.wts = tbl_wts[i];
            res.rts = tbl_rts[i];
          end
        end
        ACT_UPDATE: begin
          if (rq.wts > tbl_wts[i]) begin
            tbl_wts[i] = rq.wts;
            tbl_rts[i] = rq.rts;
          end
          res.ok = 1'b1;
        end
        ACT_RAISE: begin
          if (rq.rts > tbl_rts[i]) tbl_rts[i] = rq.rts;
          res.ok = 1'b1;
        end
        ACT_INSTALL: begin
          tbl_wts[i] = rq.wts;
          tbl_rts[i] = rq.wts;
          res.ok = 1'b1;
        end
        ACT_RENEW: begin
          if (rq.wts != tbl_wts[i]) begin
            res.ok = 1'b0;
          end else if (tbl_deleted[i]) begin
            // deleted row: lease holds only below the deletion stamp
            if (rq.rts < tbl_dts[i]) begin
              res.ok = 1'b1;
              res.rts = tbl_rts[i];
            end
          end else if (!tbl_locked[i]) begin
            if (rq.rts > tbl_rts[i]) tbl_rts[i] = rq.rts;
            res.ok = 1'b1;
            res.rts = tbl_rts[i];
          end
        end
        ACT_RELEASE: begin
          tbl_locked[i] = 1'b0;
          res.ok = 1'b1;
        end
        ACT_DELETE: begin
          tbl_deleted[i] = 1'b1;
          tbl_dts[i] = rq.wts;
          res.ok = 1'b1;
        end
        ACT_SET: begin
          tbl_wts[i] = rq.wts;
          tbl_rts[i] = rq.rts;
          res.ok = 1'b1;
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int pick_idle(input int pct_none);
    int r;
    r = $urandom_range(99);
    if (no_idle || r < pct_none) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // stamps: mostly small so comparisons go both ways, sometimes full width
  function automatic stamp_t rand_stamp();
    int r;
    r = $urandom_range(99);
    if (r < 70) return stamp_t'($urandom_range(0, 63));
    if (r < 85) return {$urandom, $urandom};
    if (r < 93) return '1;
    return '1 - stamp_t'($urandom_range(1, 3));
  endfunction

  function automatic logic [ROW_W-1:0] pick_row();
    int r;
    r = $urandom_range(99);
    if (r < 80) return ROW_W'($urandom_range(0, 7));
    if (r < 85) return ROW_W'(TB_ROWS - 1);
    return ROW_W'($urandom_range(0, TB_ROWS - 1));
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // request driver: offers queued requests and predicts each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_row_request(offered_req));
        accepted_count++;
        tx_gap = pick_idle(60);
      end
      if (in_valid && in_stall) begin
        // stalled: hold the payload
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (!pause_tx && pending_reqs.size() > 0) begin
        offered_req = pending_reqs.pop_front();
        in_action <= offered_req.action;
        in_row_index <= offered_req.row;
        in_wts_in <= offered_req.wts;
        in_rts_in <= offered_req.rts;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor: checks each transfer and applies random stall
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("result transfer with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          if (out_ok !== want.ok || out_wts_out !== want.wts || out_rts_out !== want.rts)
            flag_mismatch($sformatf("ok %0b/%0b wts %h/%h rts %h/%h (got/exp)",
                                    out_ok, want.ok, out_wts_out, want.wts,
                                    out_rts_out, want.rts));
        end
      end
      if (rx_stall_left > 0) rx_stall_left--;
      else rx_stall_left = pick_idle(75);
      out_stall <= rx_hold || (rx_stall_left != 0);
    end
  end

  // long receiver hold-off so the block fills and stalls its input
  initial begin
    wait (accepted_count >= 150);
    @(negedge clk);
    rx_hold = 1'b1;
    repeat (100) @(negedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic queue_request(input logic [ACTION_W-1:0] act, input logic [ROW_W-1:0] row,
                               input stamp_t w, input stamp_t r);
    row_request_t rq;
    rq.action = act;
    rq.row = row;
    rq.wts = w;
    rq.rts = r;
    while (pending_reqs.size() >= 4) @(negedge clk);
    pending_reqs.push_back(rq);
    random_count++;
  endtask

  // holds the sender until every outstanding result has arrived
  task automatic drain_all();
    @(negedge clk);
    pause_tx = 1'b1;
    while (in_valid || expected_results.size() != 0) @(negedge clk);
    pause_tx = 1'b0;
  endtask

  // lock, modify, release, renew and read one row; sometimes the release is dropped
  task automatic queue_txn(input logic [ROW_W-1:0] row);
    stamp_t hint;
    stamp_t w;
    stamp_t renew_w;
    int sel;
    hint = tbl_wts[row];
    sel = $urandom_range(3);
    w = ($urandom_range(9) == 0) ? rand_stamp() : hint + stamp_t'($urandom_range(0, 4)) - 64'd1;
    queue_request(ACT_LOCK, row, '0, '0);
    case (sel)
      0: begin
        queue_request(ACT_UPDATE, row, w, hint + stamp_t'($urandom_range(0, 6)));
        renew_w = (w > hint) ? w : hint;
      end
      1: begin
        queue_request(ACT_INSTALL, row, w, rand_stamp());
        renew_w = w;
      end
      2: begin
        queue_request(ACT_SET, row, w, w + stamp_t'($urandom_range(0, 6)));
        renew_w = w;
      end
      default: begin
        queue_request(ACT_RAISE, row, rand_stamp(), hint + stamp_t'($urandom_range(0, 8)));
        renew_w = hint;
      end
    endcase
    if ($urandom_range(99) < 85) queue_request(ACT_RELEASE, row, rand_stamp(), rand_stamp());
    if ($urandom_range(9) == 0) renew_w = rand_stamp();
    queue_request(ACT_RENEW, row, renew_w, renew_w + stamp_t'($urandom_range(0, 10)) - 64'd3);
    queue_request(ACT_READ, row, rand_stamp(), rand_stamp());
  endtask

  // stimulus: directed cases, then random transactions and noise
  initial begin
    logic [ACTION_W-1:0] act;
    logic [ROW_W-1:0]    row;
    int                  r;

    // fresh table, extremes, every action and the renew corner cases
    queue_request(ACT_READ, '0, '0, '0);
    queue_request(ACT_READ, ROW_W'(TB_ROWS - 1), '1, '1);
    queue_request(ACT_SET, ROW_W'(TB_ROWS - 1), '1, '1);
    queue_request(ACT_READ, ROW_W'(TB_ROWS - 1), '0, '0);
    queue_request(ACT_UPDATE, ROW_W'(TB_ROWS - 1), 64'd5, 64'd7);
    queue_request(ACT_SET, 10'd5, 64'd10, 64'd10);
    queue_request(ACT_UPDATE, 10'd5, 64'd10, 64'd3);
    queue_request(ACT_UPDATE, 10'd5, 64'd11, 64'd2);
    queue_request(ACT_RAISE, 10'd5, '0, 64'd1);
    queue_request(ACT_RAISE, 10'd5, '0, 64'd20);
    queue_request(ACT_INSTALL, 10'd5, 64'd15, '0);
    queue_request(ACT_LOCK, 10'd5, '0, '0);
    queue_request(ACT_LOCK, 10'd5, '0, '0);
    queue_request(ACT_RENEW, 10'd5, 64'd15, 64'd30);
    queue_request(ACT_RELEASE, 10'd5, '0, '0);
    queue_request(ACT_RENEW, 10'd5, 64'd14, 64'd30);
    queue_request(ACT_RENEW, 10'd5, 64'd15, 64'd30);
    queue_request(ACT_RENEW, 10'd5, 64'd15, 64'd9);
    queue_request(ACT_DELETE, 10'd5, 64'd25, '0);
    queue_request(ACT_RENEW, 10'd5, 64'd15, 64'd24);
    queue_request(ACT_RENEW, 10'd5, 64'd15, 64'd25);
    queue_request(ACT_INSTALL, 10'd5, 64'd40, '0);
    queue_request(ACT_LOCK, 10'd5, '0, '0);
    queue_request(ACT_UNDEF_LO, 10'd5, 64'd40, 64'd40);
    queue_request(ACT_UNDEF_HI, ROW_W'(TB_ROWS - 1), '1, '1);
    queue_request(ACT_RENEW, ROW_W'(TB_ROWS - 1), '1, '1);
    drain_all();

    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      // a stretch with no idling on either side
      no_idle = (random_count >= 200 && random_count < 260);
      if (random_count >= 300 && random_count < 306) drain_all();
      r = $urandom_range(99);
      row = pick_row();
      if (r < 60) begin
        queue_txn(row);
      end else begin
        r = $urandom_range(99);
        if (r < 4) act = ACT_DELETE;
        else if (r < 12) act = ACTION_W'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI));
        else act = ACTION_W'($urandom_range(ACT_READ, ACT_SET));
        if (act == ACT_DELETE) act = ($urandom_range(1) == 0) ? ACT_RENEW : ACT_DELETE;
        if (act == ACT_RENEW && $urandom_range(1) == 0)
          queue_request(act, row, tbl_wts[row], rand_stamp());
        else
          queue_request(act, row, rand_stamp(), rand_stamp());
      end
    end
    no_idle = 1'b0;

    while (pending_reqs.size() != 0) @(negedge clk);
    drain_all();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
